>>> design/tacg_pkg.sv
// ----------------------------------------------------------------------------
// tacg_pkg
// Shared types and constants for the touch armed capture gate.
// ----------------------------------------------------------------------------
package tacg_pkg;

  localparam int unsigned LevelW   = 22;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned MicW     = 32;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned MicShift = 14;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned EventW   = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 22;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CfgTouchOn  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTouchOff = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDebounce = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgArmDelay = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRecord   = 3'd4;

  // reset values
  localparam logic [LevelW-1:0] TouchOnRst  = 22'd50000;
  localparam logic [LevelW-1:0] TouchOffRst = 22'd45000;
  localparam logic [DelayW-1:0] DebounceRst = 16'd80;
  localparam logic [DelayW-1:0] ArmDelayRst = 16'd2000;
  localparam logic [LevelW-1:0] RecordRst   = 22'd10000;

  typedef enum logic [EventW-1:0] {
    EV_NONE    = 3'd0,
    EV_TOUCHED = 3'd1,
    EV_START   = 3'd2,
    EV_DONE    = 3'd3,
    EV_REARMED = 3'd4
  } event_e;

  typedef struct packed {
    logic [LevelW-1:0] touch_on;
    logic [LevelW-1:0] touch_off;
    logic [DelayW-1:0] debounce;
    logic [DelayW-1:0] arm_wait;
    logic [LevelW-1:0] record_len;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic [LevelW-1:0]  touch_level;
    logic [MicW-1:0]    mic_word;
  } item_t;

  typedef struct packed {
    logic                      sample_valid;
    logic signed [SampleW-1:0] sample_value;
    logic                      led_on;
    event_e                    event_code;
    logic [PhaseW-1:0]         phase;
  } result_t;

endpackage

>>> design/tacg_cfg.sv
// ----------------------------------------------------------------------------
// tacg_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module tacg_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tacg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tacg_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output tacg_pkg::cfg_t                    cfg_o
);

  tacg_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tacg_pkg::CfgTouchOn:  cfg_d.touch_on   = cfg_wdata_i[tacg_pkg::LevelW-1:0];
        tacg_pkg::CfgTouchOff: cfg_d.touch_off  = cfg_wdata_i[tacg_pkg::LevelW-1:0];
        tacg_pkg::CfgDebounce: cfg_d.debounce   = cfg_wdata_i[tacg_pkg::DelayW-1:0];
        tacg_pkg::CfgArmDelay: cfg_d.arm_wait   = cfg_wdata_i[tacg_pkg::DelayW-1:0];
        tacg_pkg::CfgRecord:   cfg_d.record_len = cfg_wdata_i[tacg_pkg::LevelW-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.touch_on   <= tacg_pkg::TouchOnRst;
      cfg_q.touch_off  <= tacg_pkg::TouchOffRst;
      cfg_q.debounce   <= tacg_pkg::DebounceRst;
      cfg_q.arm_wait   <= tacg_pkg::ArmDelayRst;
      cfg_q.record_len <= tacg_pkg::RecordRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/tacg_fsm.sv
// ----------------------------------------------------------------------------
// tacg_fsm
// Phase sequencer, elapsed counter and sample scaling for one item.
// ----------------------------------------------------------------------------
module tacg_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,   // item in stage register moves on
  input  tacg_pkg::item_t   item_i,
  input  tacg_pkg::cfg_t    cfg_i,
  output tacg_pkg::result_t res_o
);

  typedef enum logic [tacg_pkg::PhaseW-1:0] {
    PH_WAIT_TOUCH   = 3'd0,
    PH_DEBOUNCE     = 3'd1,
    PH_ARM          = 3'd2,
    PH_RECORD       = 3'd3,
    PH_WAIT_RELEASE = 3'd4
  } phase_e;

  localparam logic [tacg_pkg::LevelW-1:0] ElapsedMax = {tacg_pkg::LevelW{1'b1}};
  localparam logic [tacg_pkg::LevelW-1:0] ElapsedOne = {{(tacg_pkg::LevelW-1){1'b0}}, 1'b1};
  localparam logic [tacg_pkg::LevelW-tacg_pkg::DelayW-1:0] DelayPad = '0;

  phase_e                      phase_q, phase_d;
  logic [tacg_pkg::LevelW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                        led_q, led_d;
  tacg_pkg::event_e            ev;
  logic                        touched, released;

  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + ElapsedOne;
  assign touched     = item_i.touch_level >= cfg_i.touch_on;
  assign released    = item_i.touch_level <  cfg_i.touch_off;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    led_d     = led_q;
    ev        = tacg_pkg::EV_NONE;
    if (!item_i.command) begin
      elapsed_d = elapsed_inc;
      case (phase_q)
        PH_DEBOUNCE: begin
          if (!touched) begin
            phase_d = PH_WAIT_TOUCH;
          end else if (elapsed_inc >= {DelayPad, cfg_i.debounce}) begin
            elapsed_d = '0;
            phase_d   = PH_ARM;
            ev        = tacg_pkg::EV_TOUCHED;
          end
        end
        PH_ARM: begin
          if (elapsed_inc >= {DelayPad, cfg_i.arm_wait}) begin
            led_d     = 1'b1;
            elapsed_d = '0;
            phase_d   = PH_RECORD;
            ev        = tacg_pkg::EV_START;
          end
        end
        PH_RECORD: begin
          if (elapsed_inc >= cfg_i.record_len) begin
            led_d   = 1'b0;
            phase_d = PH_WAIT_RELEASE;
            ev      = tacg_pkg::EV_DONE;
          end
        end
        PH_WAIT_RELEASE: begin
          if (released) begin
            phase_d = PH_WAIT_TOUCH;
            ev      = tacg_pkg::EV_REARMED;
          end
        end
        default: begin
          phase_d = PH_WAIT_TOUCH;
          if (touched) begin
            elapsed_d = '0;
            phase_d   = PH_DEBOUNCE;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_o.sample_valid = item_i.command && (phase_q == PH_RECORD);
    res_o.sample_value = res_o.sample_valid
                       ? item_i.mic_word[tacg_pkg::MicShift +: tacg_pkg::SampleW]
                       : '0;
    res_o.led_on       = led_d;
    res_o.event_code   = ev;
    res_o.phase        = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT_TOUCH;
      elapsed_q <= '0;
      led_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      led_q     <= led_d;
    end
  end

`ifndef SYNTHESIS
  // LED is lit exactly in the recording phase
  a_led_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    led_q == (phase_q == PH_RECORD))
    else $error("led state disagrees with phase");

  // mic words never touch the sequencer state
  a_mic_no_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.command |=> $stable(phase_q) && $stable(elapsed_q))
    else $error("mic item changed sequencer state");

  // entering debounce restarts the timer
  a_debounce_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.command && phase_q == PH_WAIT_TOUCH && phase_d == PH_DEBOUNCE
    |=> elapsed_q == '0)
    else $error("elapsed not cleared on debounce entry");

  // any reported event comes with a phase change
  a_event_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev != tacg_pkg::EV_NONE |-> phase_d != phase_q)
    else $error("event without phase change");
`endif

endmodule

>>> design/touch_armed_capture_gate.sv
// ----------------------------------------------------------------------------
// touch_armed_capture_gate
// Touch-triggered recording gate with scaled microphone pass-through.
// ----------------------------------------------------------------------------
// Usage: every accepted word yields exactly one result word. Throughput is one
// word per clock while out_stall_i is low; a word passes the input register,
// then the result register, the two pipeline registers around the phase and
// scaling logic. A tick word (command 0) advances the millisecond timer and
// the phase sequencer; a mic word (command 1) passes mic_word[29:14] as a
// signed 16-bit sample while recording and is otherwise reported with
// sample_valid low. led_on, event_code and phase always show the state after
// the word. The user writes configuration through cfg_we_i/cfg_index_i/
// cfg_wdata_i while no word is held (not enforced); unknown indexes ignored.
module touch_armed_capture_gate (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write port
  input  logic                                  cfg_we_i,
  input  logic [tacg_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [tacg_pkg::CfgDataW-1:0]         cfg_wdata_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  command_i,
  input  logic [tacg_pkg::LevelW-1:0]           touch_level_i,
  input  logic signed [tacg_pkg::MicW-1:0]      mic_word_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  sample_valid_o,
  output logic signed [tacg_pkg::SampleW-1:0]   sample_value_o,
  output logic                                  led_on_o,
  output logic [tacg_pkg::EventW-1:0]           event_code_o,
  output logic [tacg_pkg::PhaseW-1:0]           phase_o
);

  tacg_pkg::cfg_t    cfg;
  tacg_pkg::item_t   item_q, item_d;
  tacg_pkg::result_t res, res_q;
  logic              item_vld_q, res_vld_q;
  logic              in_take, step, res_free;

  tacg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // result slot is free if empty or being drained this cycle
  assign res_free   = !res_vld_q || !out_stall_i;
  assign step       = item_vld_q && res_free;
  // input slot accepts when empty or when its word moves on
  assign in_stall_o = item_vld_q && !res_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.command     = command_i;
    item_d.touch_level = touch_level_i;
    item_d.mic_word    = mic_word_i;
  end

  tacg_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_take) begin
        item_vld_q <= 1'b1;
      end else if (step) begin
        item_vld_q <= 1'b0;
      end
      if (step) begin
        res_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign sample_valid_o = res_q.sample_valid;
  assign sample_value_o = res_q.sample_value;
  assign led_on_o       = res_q.led_on;
  assign event_code_o   = res_q.event_code;
  assign phase_o        = res_q.phase;

`ifndef SYNTHESIS
  // a held result word stays put until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && out_stall_i |=> res_vld_q && $stable(res_q))
    else $error("stalled result word lost or changed");

  // an item never stalls while the result slot can take it
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_vld_q && res_vld_q && out_stall_i)
    else $error("input stalled without back-pressure");

  // an offered result carries a known state
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({led_on_o, event_code_o, phase_o}))
    else $error("result word carries unknown state");
`endif

endmodule
